[rtl/star_cross_frame_matcher_macros.svh]
// Assertion macros shared by the matcher RTL
`ifndef STAR_CROSS_FRAME_MATCHER_MACROS_SVH
`define STAR_CROSS_FRAME_MATCHER_MACROS_SVH
// Implication checked on every clock edge outside reset
`define SCFM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define SCFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/scfm_pkg.sv]
// Package: shared types and codes of the star cross-frame matcher
package scfm_pkg;
    localparam int KIND_W = 2;
    localparam int FRAME_W = 3;
    localparam int COORD_W = 18;
    localparam int FLUX_W = 32;
    localparam int ELONG_W = 16;
    localparam int INDEX_W = 12;
    localparam int REFCNT_W = 13;
    localparam int FOUND_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEEING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ELONG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd4;

    // One stored source entry
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [FLUX_W-1:0]  flux;
        logic [ELONG_W-1:0] elong;
    } src_t;

    // Query reference and limits held during a scan
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [FLUX_W-1:0]  flux;
        logic               elong_ok;
        logic [2*COORD_W-1:0] seeing2;
        logic [15:0]        ratio;
        logic [ELONG_W-1:0] elong_lim;
    } qry_t;

    // Verdict of the test unit for one stored entry
    typedef struct packed {
        logic                 pass;
        logic [2*COORD_W:0]   d2;
    } verdict_t;
endpackage

[rtl/scfm_if.sv]
// Interfaces: input item channel and result channel
interface scfm_in_if;
    logic                          valid;
    logic                          ready;
    logic [scfm_pkg::KIND_W-1:0]   kind;
    logic [scfm_pkg::FRAME_W-1:0]  frame;
    logic [scfm_pkg::COORD_W-1:0]  pos_x;
    logic [scfm_pkg::COORD_W-1:0]  pos_y;
    logic [scfm_pkg::FLUX_W-1:0]   brightness;
    logic [scfm_pkg::ELONG_W-1:0]  elongation;
    modport source (output valid, kind, frame, pos_x, pos_y, brightness, elongation,
                    input ready);
    modport sink (input valid, kind, frame, pos_x, pos_y, brightness, elongation,
                  output ready);
endinterface

interface scfm_out_if;
    logic                          valid;
    logic                          ready;
    logic [scfm_pkg::FRAME_W-1:0]  out_frame;
    logic [scfm_pkg::INDEX_W-1:0]  source_index;
    logic                          last;
    modport source (output valid, out_frame, source_index, last, input ready);
    modport sink (input valid, out_frame, source_index, last, output ready);
endinterface

[rtl/scfm_test_unit.sv]
// Test unit: two-stage distance, flux and elongation check of one stored entry
module scfm_test_unit (
    input  logic                 clk,
    input  scfm_pkg::qry_t       qry,
    input  scfm_pkg::src_t       src,
    output scfm_pkg::verdict_t   verdict
);
    logic [scfm_pkg::COORD_W-1:0]     dx_reg, dy_reg;
    logic [scfm_pkg::FLUX_W+7:0]      fs256_reg, fr256_reg;
    logic [scfm_pkg::FLUX_W+15:0]     fsr_reg, frr_reg;
    logic                             el_ok_reg;
    logic [scfm_pkg::COORD_W-1:0]     dx_next, dy_next;
    logic [2*scfm_pkg::COORD_W:0]     d2;

    // Stage one: differences and flux products
    always_comb
    begin
        dx_next = (qry.x >= src.x) ? qry.x - src.x : src.x - qry.x;
        dy_next = (qry.y >= src.y) ? qry.y - src.y : src.y - qry.y;
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        fs256_reg <= {src.flux, 8'd0};
        fr256_reg <= {qry.flux, 8'd0};
        fsr_reg   <= src.flux * qry.ratio;
        frr_reg   <= qry.flux * qry.ratio;
        el_ok_reg <= qry.elong_ok && (src.elong < qry.elong_lim);
    end

    // Stage two: squares, sum and compares
    always_comb
    begin
        d2 = {1'b0, (2*scfm_pkg::COORD_W)'(dx_reg) * (2*scfm_pkg::COORD_W)'(dx_reg)}
             + {1'b0, (2*scfm_pkg::COORD_W)'(dy_reg) * (2*scfm_pkg::COORD_W)'(dy_reg)};
        verdict.d2 = d2;
        verdict.pass = (d2 < {1'b0, qry.seeing2}) && el_ok_reg
                       && ({8'd0, fs256_reg} < frr_reg) && (fsr_reg > {8'd0, fr256_reg});
    end
endmodule

[rtl/star_cross_frame_matcher.sv]
// Flow: a load, clear, ignored or over-limit query goes through S_DONE only; a query
// scans the stored frames in order, stopping at the first frame without a match, and
// then emits one result per frame, each held while the output is stalled.
// Throughput: one item at a time, the scan reading one stored entry per cycle from the
// single read port; no item is taken until all results of the previous one are out.
// Reset: rst_n asynchronously clears control, fills, counters and config registers to defaults.
`include "star_cross_frame_matcher_macros.svh"
module star_cross_frame_matcher #(
    parameter int MAX_SOURCES = 4096,
    parameter int MAX_FRAMES  = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    scfm_in_if.sink                           in_ch,
    scfm_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [scfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [scfm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    localparam int SLOTS  = MAX_FRAMES - 1;
    localparam int LW     = $clog2(MAX_SOURCES);
    localparam int FILL_W = LW + 1;
    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW     = $clog2(SLOTS * MAX_SOURCES);

    typedef enum logic [2:0] {S_IDLE, S_START, S_SCAN, S_DRAIN, S_NEXT, S_EMIT, S_DONE}
        state_t;

    state_t state_reg;
    logic [2:0]  frames_reg;
    logic [17:0] seeing_reg;
    logic [15:0] ratio_reg, elong_lim_reg, limit_reg;
    logic [FILL_W-1:0] fill_reg [SLOTS];
    logic [scfm_pkg::REFCNT_W-1:0] refcnt_reg, query_reg;
    logic [scfm_pkg::FOUND_W-1:0]  found_reg;
    logic [scfm_pkg::INDEX_W-1:0]  best_reg [SLOTS];
    logic [3:0]  nf_reg;
    logic [3:0]  frame_reg;          // current frame under scan or emit
    logic [FILL_W-1:0] addr_cnt_reg; // issue counter
    logic [LW-1:0] idx1_reg, idx2_reg;
    logic v1_reg, v2_reg;
    logic have_reg;
    logic [2*scfm_pkg::COORD_W:0] dmin_reg;
    scfm_pkg::qry_t qry_reg;
    scfm_pkg::src_t mem [SLOTS * MAX_SOURCES];
    scfm_pkg::src_t rd_reg;
    scfm_pkg::verdict_t verdict;
    logic out_valid_reg, out_last_reg;
    logic [2:0] out_frame_reg;
    logic [scfm_pkg::INDEX_W-1:0] out_idx_reg;

    logic in_fire, out_fire, load_ok;
    logic [SW-1:0] load_slot, scan_slot;
    logic [3:0] nf_eff;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign load_slot = SW'(in_ch.frame - 3'd1);
    assign scan_slot = SW'(frame_reg - 4'd1);
    assign load_ok = (in_ch.frame != 3'd0) && (32'(in_ch.frame) < MAX_FRAMES)
                     && (fill_reg[load_slot] < FILL_W'(MAX_SOURCES));
    always_comb
    begin
        if (frames_reg == 3'd0)
            nf_eff = 4'd1;
        else if (32'(frames_reg) > MAX_FRAMES)
            nf_eff = 4'(MAX_FRAMES);
        else
            nf_eff = {1'b0, frames_reg};
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_frame    = out_frame_reg;
    assign out_ch.source_index = out_idx_reg;
    assign out_ch.last         = out_last_reg;

    scfm_test_unit u_test (.clk(clk), .qry(qry_reg), .src(rd_reg), .verdict(verdict));

    // Source memory: write on load, read one entry per scan cycle
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.kind == scfm_pkg::KIND_LOAD && load_ok)
            mem[AW'({load_slot, LW'(fill_reg[load_slot])})] <=
                '{x: in_ch.pos_x, y: in_ch.pos_y, flux: in_ch.brightness,
                  elong: in_ch.elongation};
        rd_reg <= mem[AW'({scan_slot, addr_cnt_reg[LW-1:0]})];
    end

    // Sequencer, counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            frames_reg <= 3'd2;
            seeing_reg <= 18'd48;
            ratio_reg <= 16'd512;
            elong_lim_reg <= 16'd512;
            limit_reg <= 16'd100;
            for (int i = 0; i < SLOTS; i++)
                fill_reg[i] <= '0;
            refcnt_reg <= '0;
            found_reg <= '0;
            out_valid_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    scfm_pkg::REG_FRAMES: frames_reg    <= cfg_data[2:0];
                    scfm_pkg::REG_SEEING: seeing_reg    <= cfg_data;
                    scfm_pkg::REG_RATIO:  ratio_reg     <= cfg_data[15:0];
                    scfm_pkg::REG_ELONG:  elong_lim_reg <= cfg_data[15:0];
                    scfm_pkg::REG_LIMIT:  limit_reg     <= cfg_data[15:0];
                    default: ;
                endcase
            end
            // advance the two-deep read/test pipe tags
            v1_reg   <= (state_reg == S_SCAN) && (addr_cnt_reg < fill_reg[scan_slot]);
            idx1_reg <= addr_cnt_reg[LW-1:0];
            v2_reg   <= v1_reg;
            idx2_reg <= idx1_reg;
            if (v2_reg && verdict.pass && (!have_reg || verdict.d2 < dmin_reg))
            begin
                have_reg <= 1'b1;
                dmin_reg <= verdict.d2;
                best_reg[scan_slot] <= scfm_pkg::INDEX_W'(idx2_reg);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (in_ch.kind)
                            scfm_pkg::KIND_CLEAR:
                            begin
                                for (int i = 0; i < SLOTS; i++)
                                    fill_reg[i] <= '0;
                                refcnt_reg <= '0;
                                found_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            scfm_pkg::KIND_LOAD:
                            begin
                                if (load_ok)
                                    fill_reg[load_slot] <= fill_reg[load_slot] + 1'b1;
                                state_reg <= S_DONE;
                            end
                            scfm_pkg::KIND_QUERY:
                            begin
                                refcnt_reg <= refcnt_reg + 1'b1;
                                query_reg <= refcnt_reg;
                                nf_reg <= nf_eff;
                                qry_reg <= '{x: in_ch.pos_x, y: in_ch.pos_y,
                                    flux: in_ch.brightness,
                                    elong_ok: in_ch.elongation < elong_lim_reg,
                                    seeing2: (2*scfm_pkg::COORD_W)'(seeing_reg)
                                             * (2*scfm_pkg::COORD_W)'(seeing_reg),
                                    ratio: ratio_reg, elong_lim: elong_lim_reg};
                                state_reg <= (found_reg < limit_reg) ? S_START : S_DONE;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_START:
                begin
                    addr_cnt_reg <= '0;
                    have_reg <= 1'b0;
                    frame_reg <= (nf_reg == 4'd1) ? 4'd0 : 4'd1;
                    state_reg <= (nf_reg == 4'd1) ? S_EMIT : S_SCAN;
                end
                S_SCAN:
                begin
                    if (addr_cnt_reg >= fill_reg[scan_slot])
                        state_reg <= S_DRAIN;
                    else
                        addr_cnt_reg <= addr_cnt_reg + 1'b1;
                end
                S_DRAIN:
                    if (!v1_reg && !v2_reg)
                        state_reg <= S_NEXT;
                S_NEXT:
                begin
                    addr_cnt_reg <= '0;
                    have_reg <= 1'b0;
                    if (!have_reg)
                        state_reg <= S_DONE;
                    else if (frame_reg + 4'd1 >= nf_reg)
                    begin
                        frame_reg <= 4'd0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        frame_reg <= frame_reg + 4'd1;
                        state_reg <= S_SCAN;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        out_frame_reg <= frame_reg[2:0];
                        out_idx_reg <= (frame_reg == 4'd0)
                            ? query_reg[scfm_pkg::INDEX_W-1:0] : best_reg[scan_slot];
                        out_last_reg <= (frame_reg + 4'd1 == nf_reg);
                        if (frame_reg == 4'd0)
                            found_reg <= found_reg + 1'b1;
                        if (frame_reg + 4'd1 == nf_reg)
                            state_reg <= S_DONE;
                        else
                            frame_reg <= frame_reg + 4'd1;
                    end
                end
                S_DONE:
                begin
                    if (out_fire)
                        out_valid_reg <= 1'b0;
                    if (!out_valid_reg || out_fire)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `SCFM_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, !out_valid_reg,
        "ready with result pending")
    `SCFM_ASSERT_IMP(a_scan_frame, clk, rst_n, state_reg == S_SCAN,
        frame_reg != 4'd0 && frame_reg < nf_reg, "scan frame out of range")
    `SCFM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !out_ch.ready,
        out_valid_reg && $stable(out_idx_reg) && $stable(out_frame_reg)
        && $stable(out_last_reg), "result word changed while stalled")
endmodule
